[rtl/srsw_pkg.sv]
// Shared types and constants for the selective-repeat sender window.
// Holds command/status codes, controller states and the controller/datapath structs.
// No dependencies.
package srsw_pkg;

	localparam int MaxFrames = 16;
	localparam int MaxWindow = 8;
	localparam int FrameW    = $clog2(MaxFrames);
	localparam int CountW    = FrameW + 1;
	localparam int TotalW    = 5;
	localparam int WindowW   = 4;
	localparam int AckNumW   = 8;
	localparam int CfgDataW  = 5;

	localparam logic [TotalW-1:0]  TotalReset  = TotalW'(10);
	localparam logic [WindowW-1:0] WindowReset = WindowW'(4);

	typedef enum logic [1:0] {
		CMD_SEND = 2'd0,
		CMD_ACK  = 2'd1,
		CMD_BAD  = 2'd2,
		CMD_RSVD = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACK_NONE    = 2'd0,
		ACK_NEW     = 2'd1,
		ACK_DUP     = 2'd2,
		ACK_IGNORED = 2'd3
	} ack_status_t;

	typedef enum logic {
		REG_TOTAL  = 1'b0,
		REG_WINDOW = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLIDE,
		ST_SEND,
		ST_ACK,
		ST_SLIDE_ACK
	} state_t;

	typedef enum logic [1:0] {
		OUT_FRAME,
		OUT_DONE,
		OUT_ACK
	} out_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     latch_in;
		logic     base_inc;
		logic     cur_load;
		logic     cur_inc;
		logic     mark_ack;
		logic     out_load;
		out_sel_t out_sel;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic slide_go;
		logic base_done;
		logic cur_in_range;
		logic cur_unacked;
		logic cur_last;
		logic slot_free;
	} stat_t;

endpackage

[rtl/srsw_ctrl.sv]
// Controller state machine for the selective-repeat sender window.
// Sequences slide, send scan and ack update; depends on srsw_pkg.
module srsw_ctrl
	import srsw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		ctrl.out_sel = OUT_FRAME;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctrl.latch_in = 1'b1;
					state_d = ST_SLIDE;
				end
			end
			ST_SLIDE: begin
				if (stat.slide_go) begin
					ctrl.base_inc = 1'b1;
				end else begin
					case (stat.cmd)
						CMD_SEND: begin
							if (stat.base_done) begin
								// hold until the output register can take the beat
								if (stat.slot_free) begin
									ctrl.out_load = 1'b1;
									ctrl.out_sel  = OUT_DONE;
									state_d = ST_IDLE;
								end
							end else begin
								ctrl.cur_load = 1'b1;
								state_d = ST_SEND;
							end
						end
						CMD_ACK: state_d = ST_ACK;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEND: begin
				if (!stat.cur_in_range) begin
					state_d = ST_IDLE;
				end else if (stat.cur_unacked) begin
					if (stat.slot_free) begin
						ctrl.out_load = 1'b1;
						ctrl.out_sel  = OUT_FRAME;
						ctrl.cur_inc  = 1'b1;
						if (stat.cur_last) begin
							state_d = ST_IDLE;
						end
					end
				end else begin
					ctrl.cur_inc = 1'b1;
				end
			end
			ST_ACK: begin
				ctrl.mark_ack = 1'b1;
				state_d = ST_SLIDE_ACK;
			end
			ST_SLIDE_ACK: begin
				if (stat.slide_go) begin
					ctrl.base_inc = 1'b1;
				end else if (stat.slot_free) begin
					ctrl.out_load = 1'b1;
					ctrl.out_sel  = OUT_ACK;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[rtl/srsw_dp.sv]
// Datapath for the selective-repeat sender window: config registers, ack bitmap,
// window base, scan cursor and output register. Depends on srsw_pkg.
module srsw_dp
	import srsw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic [1:0]          command,
	input  logic [AckNumW-1:0]  ack_number,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [FrameW-1:0]   frame_number,
	output logic                send_valid,
	output logic                last,
	output logic [1:0]          ack_status,
	output logic                all_done,
	input  ctrl_t               ctrl,
	output stat_t               stat
);

	logic [TotalW-1:0]    total_q;
	logic [WindowW-1:0]   window_q;
	logic [MaxFrames-1:0] acked_q;
	logic [CountW-1:0]    base_q;
	logic [CountW-1:0]    cur_q;
	logic [CountW-1:0]    end_q;
	cmd_t                 cmd_q;
	logic [AckNumW-1:0]   ack_q;
	ack_status_t          status_q;

	logic [CountW-1:0]  total_eff;
	logic [CountW-1:0]  win_eff;
	logic [CountW:0]    end_sum;
	logic [CountW-1:0]  end_d;
	logic               more;
	logic               out_valid_q;

	// clamp configuration to the supported range
	always_comb begin
		if (total_q > TotalW'(MaxFrames)) begin
			total_eff = CountW'(MaxFrames);
		end else begin
			total_eff = CountW'(total_q);
		end
		if (window_q == '0) begin
			win_eff = CountW'(1);
		end else if (window_q > WindowW'(MaxWindow)) begin
			win_eff = CountW'(MaxWindow);
		end else begin
			win_eff = CountW'(window_q);
		end
		end_sum = {1'b0, base_q} + {1'b0, win_eff};
		if (end_sum > {1'b0, total_eff}) begin
			end_d = total_eff;
		end else begin
			end_d = end_sum[CountW-1:0];
		end
	end

	// any unacked frame after the cursor still inside the window
	always_comb begin
		more = 1'b0;
		for (int j = 0; j < MaxFrames; j++) begin
			if (CountW'(j) > cur_q && CountW'(j) < end_q && !acked_q[j]) begin
				more = 1'b1;
			end
		end
	end

	always_comb begin
		stat.cmd          = cmd_q;
		stat.slide_go     = (base_q < total_eff) && (base_q < CountW'(MaxFrames))
		                    && acked_q[base_q[FrameW-1:0]];
		stat.base_done    = (base_q >= total_eff);
		stat.cur_in_range = (cur_q < end_q);
		stat.cur_unacked  = !acked_q[cur_q[FrameW-1:0]];
		stat.cur_last     = !more;
		stat.slot_free    = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= TotalReset;
			window_q <= WindowReset;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_TOTAL:  total_q  <= cfg_data[TotalW-1:0];
				REG_WINDOW: window_q <= cfg_data[WindowW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acked_q  <= '0;
			base_q   <= '0;
			cmd_q    <= CMD_SEND;
			status_q <= ACK_NONE;
		end else begin
			if (ctrl.latch_in) begin
				cmd_q <= cmd_t'(command);
			end
			if (ctrl.base_inc) begin
				base_q <= base_q + CountW'(1);
			end
			if (ctrl.mark_ack) begin
				if (ack_q >= AckNumW'(total_eff)) begin
					status_q <= ACK_IGNORED;
				end else if (acked_q[ack_q[FrameW-1:0]]) begin
					status_q <= ACK_DUP;
				end else begin
					acked_q[ack_q[FrameW-1:0]] <= 1'b1;
					status_q <= ACK_NEW;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch_in) begin
			ack_q <= ack_number;
		end
		if (ctrl.cur_load) begin
			cur_q <= base_q;
			end_q <= end_d;
		end else if (ctrl.cur_inc) begin
			cur_q <= cur_q + CountW'(1);
		end
	end

	// output register: load when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			case (ctrl.out_sel)
				OUT_FRAME: begin
					frame_number <= cur_q[FrameW-1:0];
					send_valid   <= 1'b1;
					last         <= !more;
					ack_status   <= ACK_NONE;
					all_done     <= 1'b0;
				end
				OUT_DONE: begin
					frame_number <= '0;
					send_valid   <= 1'b0;
					last         <= 1'b1;
					ack_status   <= ACK_NONE;
					all_done     <= 1'b1;
				end
				default: begin
					frame_number <= '0;
					send_valid   <= 1'b0;
					last         <= 1'b1;
					ack_status   <= status_q;
					all_done     <= (base_q >= total_eff);
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/selective_repeat_sender_window_core.sv]
// Selective-repeat ARQ sender window. Before each command the window base steps
// over acknowledged frames at one frame per cycle, since the ack bitmap is read
// one entry per cycle. A send command then scans the window, one frame number per
// cycle while the output is not stalled, emitting each unacknowledged frame (up to 8
// beats, last one marked), or a single done beat once every frame is acknowledged.
// An ack gives one status beat; a malformed reply gives none.
// Output beats are held in a register, so a stalled output only pauses the scan.
// Top level: instantiates srsw_ctrl and srsw_dp; depends on srsw_pkg.
module selective_repeat_sender_window_core
	import srsw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          command,
	input  logic [AckNumW-1:0]  ack_number,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [FrameW-1:0]   frame_number,
	output logic                send_valid,
	output logic                last,
	output logic [1:0]          ack_status,
	output logic                all_done
);

	ctrl_t ctrl;
	stat_t stat;

	srsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	srsw_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.ack_number   (ack_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_number (frame_number),
		.send_valid   (send_valid),
		.last         (last),
		.ack_status   (ack_status),
		.all_done     (all_done),
		.ctrl         (ctrl),
		.stat         (stat)
	);

endmodule

[dv/tb_selective_repeat_sender_window_core.sv]
// Self-checking testbench for selective_repeat_sender_window_core: directed and random
// send/ack traffic across several window settings, checked beat by beat.
// Depends on srsw_pkg and the RTL top level only.
module tb_selective_repeat_sender_window_core;
	timeunit 1ns;
	timeprecision 1ps;
	import srsw_pkg::*;

	localparam int SettleCycles = 40;
	localparam int RandomItems  = 352;
	localparam int NumPhases    = 8;

	typedef struct packed {
		logic [FrameW-1:0] frame;
		logic              send_valid;
		logic              last;
		ack_status_t       status;
		logic              done;
	} window_beat_t;

	// Mirrors the sender window: ack bitmap, base and both registers.
	class window_scoreboard;
		bit                 acked [MaxFrames];
		int unsigned        base;
		logic [TotalW-1:0]  total_reg;
		logic [WindowW-1:0] window_reg;
		window_beat_t       expected_beats[$];
		int                 mismatches;

		function new();
			foreach (acked[i]) acked[i] = 1'b0;
			base       = 0;
			total_reg  = TotalReset;
			window_reg = WindowReset;
			mismatches = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [CfgDataW-1:0] data);
			if (idx == REG_TOTAL) begin
				total_reg = data[TotalW-1:0];
			end else begin
				window_reg = data[WindowW-1:0];
			end
		endfunction

		function int unsigned frame_limit();
			return (int'(total_reg) > MaxFrames) ? MaxFrames : int'(total_reg);
		endfunction

		function int unsigned window_span();
			int unsigned w;
			w = window_reg;
			if (w > MaxWindow) w = MaxWindow;
			if (w == 0) w = 1;
			return w;
		endfunction

		// Advance the base past acknowledged frames, bound checked first.
		function void skip_acked(int unsigned lim);
			while (base < lim && base < MaxFrames && acked[base]) base++;
		endfunction

		function void predict_window_beats(cmd_t cmd, logic [AckNumW-1:0] ackn);
			int unsigned lim;
			int unsigned stop;
			int          first;
			ack_status_t st;
			window_beat_t b;
			lim = frame_limit();
			skip_acked(lim);
			case (cmd)
				CMD_SEND: begin
					if (base >= lim) begin
						b = '{frame: '0, send_valid: 1'b0, last: 1'b1, status: ACK_NONE,
							done: 1'b1};
						expected_beats.push_back(b);
					end else begin
						stop  = base + window_span();
						if (stop > lim) stop = lim;
						first = expected_beats.size();
						for (int unsigned i = base; i < stop; i++) begin
							if (!acked[i]) begin
								b = '{frame: FrameW'(i), send_valid: 1'b1, last: 1'b0,
									status: ACK_NONE, done: 1'b0};
								expected_beats.push_back(b);
							end
						end
						// mark the final frame of this window
						if (expected_beats.size() > first)
							expected_beats[$].last = 1'b1;
					end
				end
				CMD_ACK: begin
					if (ackn >= lim) begin
						st = ACK_IGNORED;
					end else if (acked[ackn]) begin
						st = ACK_DUP;
					end else begin
						acked[ackn] = 1'b1;
						st = ACK_NEW;
					end
					skip_acked(lim);
					b = '{frame: '0, send_valid: 1'b0, last: 1'b1, status: st,
						done: (base >= lim)};
					expected_beats.push_back(b);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("[%0t] window beat error: %s", $time, msg);
			mismatches++;
		endtask

		task check_beat(window_beat_t got);
			window_beat_t want;
			if (expected_beats.size() == 0) begin
				report($sformatf("unexpected beat frame %0d valid %0d last %0d status %0d",
					got.frame, got.send_valid, got.last, got.status));
			end else begin
				want = expected_beats.pop_front();
				if (got.frame !== want.frame)
					report($sformatf("frame_number %0d, predicted %0d", got.frame, want.frame));
				if (got.send_valid !== want.send_valid)
					report($sformatf("send_valid %0d, predicted %0d", got.send_valid,
						want.send_valid));
				if (got.last !== want.last)
					report($sformatf("last %0d, predicted %0d", got.last, want.last));
				if (got.status !== want.status)
					report($sformatf("ack_status %0d, predicted %0d", got.status, want.status));
				if (got.done !== want.done)
					report($sformatf("all_done %0d, predicted %0d", got.done, want.done));
			end
		endtask
	endclass

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_we     = 1'b0;
	logic                cfg_index  = 1'b0;
	logic [CfgDataW-1:0] cfg_data   = '0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [1:0]          command    = '0;
	logic [AckNumW-1:0]  ack_number = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [FrameW-1:0]   frame_number;
	logic                send_valid;
	logic                last;
	logic [1:0]          ack_status;
	logic                all_done;

	int               src_idle_pct   = 0;
	int               sink_stall_pct = 0;
	window_scoreboard sb;

	selective_repeat_sender_window_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.ack_number   (ack_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_number (frame_number),
		.send_valid   (send_valid),
		.last         (last),
		.ack_status   (ack_status),
		.all_done     (all_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	always @(posedge clk) begin : watch_results
		window_beat_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{frame: frame_number, send_valid: send_valid, last: last,
				status: ack_status_t'(ack_status), done: all_done};
			sb.check_beat(got);
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic push_command(input cmd_t cmd, input logic [AckNumW-1:0] ackn);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		ack_number <= ackn;
		do @(posedge clk); while (in_stall);
		sb.predict_window_beats(cmd, ackn);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.expected_beats.size() != 0) @(negedge clk);
		// a malformed reply may still be sliding the base
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic load_config(input logic [TotalW-1:0] total,
		input logic [WindowW-1:0] window);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TOTAL;
		cfg_data  <= CfgDataW'(total);
		@(negedge clk);
		cfg_index <= REG_WINDOW;
		cfg_data  <= CfgDataW'(window);
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(REG_TOTAL, CfgDataW'(total));
		sb.write_reg(REG_WINDOW, CfgDataW'(window));
	endtask

	// Mostly sends and acks near the current window; some stray acks and bad replies.
	task automatic random_item(output bit counted);
		int unsigned        pick;
		int unsigned        aim;
		logic [AckNumW-1:0] ackn;
		pick    = $urandom_range(99);
		counted = 1'b1;
		if (pick < 50) begin
			push_command(CMD_SEND, AckNumW'($urandom));
		end else if (pick < 85) begin
			aim = $urandom_range(99);
			if (aim < 60)
				ackn = AckNumW'(sb.base + $urandom_range(sb.window_span()));
			else if (aim < 85)
				ackn = AckNumW'($urandom_range(MaxFrames + 1));
			else
				ackn = AckNumW'($urandom);
			push_command(CMD_ACK, ackn);
		end else if (pick[0]) begin
			push_command(CMD_BAD, AckNumW'($urandom));
		end else begin
			push_command(CMD_RSVD, AckNumW'($urandom));
		end
	endtask

	initial begin : stimulus
		logic [TotalW-1:0]  totals  [NumPhases];
		logic [WindowW-1:0] windows [NumPhases];
		int                 sent;
		bit                 counted;
		totals  = '{5'd1, 5'd3, 5'd5, 5'd8, 5'd12, 5'd0, 5'd16, 5'd31};
		windows = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd7, 4'd2, 4'd5};
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: ten frames, window of four
		push_command(CMD_SEND, 8'd0);
		push_command(CMD_ACK, 8'd0);
		push_command(CMD_ACK, 8'd0);
		push_command(CMD_ACK, 8'd2);
		push_command(CMD_SEND, 8'hff);
		push_command(CMD_ACK, 8'd10);
		push_command(CMD_ACK, 8'd255);
		push_command(CMD_ACK, 8'd9);
		push_command(CMD_BAD, 8'd1);
		push_command(CMD_RSVD, 8'd1);
		push_command(CMD_ACK, 8'd1);
		push_command(CMD_SEND, 8'd0);
		drain_results();
		// empty transfer, zero window
		load_config(5'd0, 4'd0);
		push_command(CMD_SEND, 8'd0);
		push_command(CMD_ACK, 8'd0);
		drain_results();
		// window above its limit, transfer already complete
		load_config(5'd3, 4'd15);
		push_command(CMD_ACK, 8'd3);
		push_command(CMD_SEND, 8'd0);
		drain_results();
		// total above its limit, full window
		load_config(5'd31, 4'd8);
		push_command(CMD_SEND, 8'd0);
		push_command(CMD_ACK, 8'd15);
		push_command(CMD_ACK, 8'd16);
		push_command(CMD_SEND, 8'd0);
		drain_results();

		for (int p = 0; p < NumPhases; p++) begin
			load_config(totals[p], windows[p]);
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
				default: begin src_idle_pct = 30; sink_stall_pct = 30; end
			endcase
			sent = 0;
			while (sent < RandomItems / NumPhases) begin
				random_item(counted);
				if (counted) sent++;
			end
			drain_results();
		end

		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin : watchdog
		#6_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[selective_repeat_sender_window_core.f]
rtl/srsw_pkg.sv
rtl/srsw_ctrl.sv
rtl/srsw_dp.sv
rtl/selective_repeat_sender_window_core.sv
dv/tb_selective_repeat_sender_window_core.sv
